@@ rtl/core/ibec_pkg.sv @@
package ibec_pkg;

  localparam int WORD_BITS  = 64;
  localparam int WORD_SHIFT = 6;
  localparam int CMD_W      = 2;
  localparam int INDEX_W    = 8;
  localparam int SIZE_W     = 9;
  localparam int SIZE_MAX   = (1 << SIZE_W) - 1;
  // Words that a set size can ever reach; eight at most.
  localparam int WSEL_W     = 3;

  typedef logic [WORD_BITS-1:0]  word_t;
  typedef logic [CMD_W-1:0]      cmd_t;
  typedef logic [SIZE_W-1:0]     size_t;
  typedef logic [WORD_SHIFT-1:0] bitpos_t;

  localparam cmd_t CMD_FILL       = 2'd0;
  localparam cmd_t CMD_TOGGLE     = 2'd1;
  localparam cmd_t CMD_QUERY      = 2'd2;
  localparam cmd_t CMD_COMPLEMENT = 2'd3;

  // Bits of word wi that lie below the live set size.
  function automatic word_t word_mask(input logic [WSEL_W-1:0] wi, input size_t live);
    logic [SIZE_W:0] base;
    logic [SIZE_W:0] top;
    logic [SIZE_W:0] rem;
    word_t           m;
    base = {1'b0, wi, {WORD_SHIFT{1'b0}}};
    top  = base + (SIZE_W+1)'(WORD_BITS);
    rem  = {1'b0, live} - base;
    if ({1'b0, live} >= top) begin
      m = '1;
    end else if ({1'b0, live} <= base) begin
      m = '0;
    end else begin
      m = ~({WORD_BITS{1'b1}} << rem[WORD_SHIFT-1:0]);
    end
    return m;
  endfunction

  function automatic logic [WORD_SHIFT:0] ones_in(input word_t v);
    logic [WORD_SHIFT:0] c;
    c = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      c = c + (WORD_SHIFT+1)'(v[i]);
    end
    return c;
  endfunction

  function automatic bitpos_t high_bit(input word_t v);
    bitpos_t p;
    p = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (v[i]) begin
        p = bitpos_t'(i);
      end
    end
    return p;
  endfunction

endpackage

@@ rtl/core/index_bitmap_extract_count_top.sv @@
// Index bitmap over indices below set_size, held as 64-bit words in flip-flops.
// Each transaction (fill, toggle, query, complement) is taken only while the
// block is idle; a small sequencer then walks the stored words one per cycle
// through a single shared unit that rewrites the word, counts its ones and
// finds its highest set bit. W = ceil(min(MAX_INDICES, 511) / 64) is the number
// of stored words (W = 4 at the default). The result is registered, so the next
// transaction may be taken while a result still waits. After reset and after
// every write of set_size the map is refilled by the same walk, during which
// in_ready is low.
module index_bitmap_extract_count_top
  import ibec_pkg::*;
#(
  parameter int MAX_INDICES = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [SIZE_W-1:0]  cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [CMD_W-1:0]   in_command,
  input  logic [INDEX_W-1:0] in_index,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_is_member,
  output logic [INDEX_W-1:0] out_extracted_index,
  output logic [SIZE_W-1:0]  out_member_count,
  output logic               out_map_empty,
  output logic               out_index_error
);

  localparam int CAP         = (MAX_INDICES < SIZE_MAX) ? MAX_INDICES : SIZE_MAX;
  localparam int STORE_WORDS = (CAP + WORD_BITS - 1) / WORD_BITS;
  localparam int WIDX        = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;
  localparam int EXT_W       = WIDX + WORD_SHIFT;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_WALK = 2'd1;
  localparam logic [1:0] ST_HOLD = 2'd2;

  logic [1:0]         state_r, state_nxt;
  logic [WIDX-1:0]    wcnt_r, wcnt_nxt;
  logic               refill_r, refill_nxt;
  cmd_t               cmd_r, cmd_nxt;
  logic [INDEX_W-1:0] idx_r, idx_nxt;
  logic               bad_r, bad_nxt;
  logic               found_r, found_nxt;
  logic [INDEX_W-1:0] ext_r, ext_nxt;
  size_t              count_r, count_nxt;
  logic               member_r, member_nxt;
  size_t              set_size_r, set_size_nxt;
  word_t              words_r [STORE_WORDS];

  logic               out_valid_r, out_valid_nxt;
  logic               out_member_r, out_member_nxt;
  logic [INDEX_W-1:0] out_ext_r, out_ext_nxt;
  size_t              out_count_r, out_count_nxt;
  logic               out_empty_r, out_empty_nxt;
  logic               out_err_r, out_err_nxt;

  size_t              live;
  cmd_t               op;
  word_t              cur, mask, vn;
  logic               at_w, last, wr_en, slot_free, accept;
  logic [EXT_W-1:0]   ext_full;
  size_t              cnt_w;
  logic               found_w;
  logic [INDEX_W-1:0] ext_w;
  logic               member_w;

  assign live      = (set_size_r > size_t'(CAP)) ? size_t'(CAP) : set_size_r;
  assign in_ready  = (state_r == ST_IDLE) && !cfg_we;
  assign accept    = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;

  // Shared word unit: rewrite the current word, then count and encode it.
  always_comb begin
    op    = refill_r ? CMD_FILL : cmd_r;
    cur   = words_r[wcnt_r];
    mask  = word_mask(WSEL_W'(wcnt_r), live);
    at_w  = ({{(INDEX_W-2){1'b0}}, idx_r[INDEX_W-1:WORD_SHIFT]} == INDEX_W'(wcnt_r));
    last  = (wcnt_r == WIDX'(STORE_WORDS - 1));
    case (op)
      CMD_FILL:       vn = mask;
      CMD_TOGGLE:     vn = (at_w && !bad_r) ? (cur ^ (word_t'(1) << idx_r[WORD_SHIFT-1:0]))
                                            : cur;
      CMD_COMPLEMENT: vn = ~cur & mask;
      default:        vn = cur;
    endcase
    ext_full = {wcnt_r, high_bit(vn)};
    cnt_w    = count_r + size_t'(ones_in(vn));
    found_w  = found_r || (vn != '0);
    ext_w    = (!found_r && (vn != '0)) ? INDEX_W'(ext_full) : ext_r;
    member_w = at_w ? (!bad_r && vn[idx_r[WORD_SHIFT-1:0]]) : member_r;
  end

  always_comb begin
    state_nxt      = state_r;
    wcnt_nxt       = wcnt_r;
    refill_nxt     = refill_r;
    cmd_nxt        = cmd_r;
    idx_nxt        = idx_r;
    bad_nxt        = bad_r;
    found_nxt      = found_r;
    ext_nxt        = ext_r;
    count_nxt      = count_r;
    member_nxt     = member_r;
    set_size_nxt   = set_size_r;
    wr_en          = 1'b0;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_member_nxt = out_member_r;
    out_ext_nxt    = out_ext_r;
    out_count_nxt  = out_count_r;
    out_empty_nxt  = out_empty_r;
    out_err_nxt    = out_err_r;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt  = ST_WALK;
          wcnt_nxt   = '0;
          cmd_nxt    = in_command;
          idx_nxt    = in_index;
          bad_nxt    = ({1'b0, in_index} >= live);
          found_nxt  = 1'b0;
          ext_nxt    = '0;
          count_nxt  = '0;
          member_nxt = 1'b0;
        end
      end
      ST_WALK: begin
        wr_en      = 1'b1;
        wcnt_nxt   = wcnt_r + WIDX'(1);
        found_nxt  = found_w;
        ext_nxt    = ext_w;
        count_nxt  = cnt_w;
        member_nxt = member_w;
        if (last) begin
          wcnt_nxt = '0;
          if (refill_r) begin
            refill_nxt = 1'b0;
            state_nxt  = ST_IDLE;
          end else if (slot_free) begin
            state_nxt      = ST_IDLE;
            out_valid_nxt  = 1'b1;
            out_member_nxt = member_w;
            out_ext_nxt    = found_w ? ext_w : '0;
            out_count_nxt  = cnt_w;
            out_empty_nxt  = !found_w;
            out_err_nxt    = bad_r;
          end else begin
            state_nxt = ST_HOLD;
          end
        end
      end
      ST_HOLD: begin
        if (slot_free) begin
          state_nxt      = ST_IDLE;
          out_valid_nxt  = 1'b1;
          out_member_nxt = member_r;
          out_ext_nxt    = found_r ? ext_r : '0;
          out_count_nxt  = count_r;
          out_empty_nxt  = !found_r;
          out_err_nxt    = bad_r;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // A new set size reloads the whole map.
    if (cfg_we) begin
      set_size_nxt = cfg_data;
      refill_nxt   = 1'b1;
      wcnt_nxt     = '0;
      state_nxt    = ST_WALK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_WALK;
      refill_r    <= 1'b1;
      wcnt_r      <= '0;
      set_size_r  <= size_t'(256);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      refill_r    <= refill_nxt;
      wcnt_r      <= wcnt_nxt;
      set_size_r  <= set_size_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    idx_r        <= idx_nxt;
    bad_r        <= bad_nxt;
    found_r      <= found_nxt;
    ext_r        <= ext_nxt;
    count_r      <= count_nxt;
    member_r     <= member_nxt;
    out_member_r <= out_member_nxt;
    out_ext_r    <= out_ext_nxt;
    out_count_r  <= out_count_nxt;
    out_empty_r  <= out_empty_nxt;
    out_err_r    <= out_err_nxt;
    if (wr_en) begin
      words_r[wcnt_r] <= vn;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_is_member       = out_member_r;
  assign out_extracted_index = out_ext_r;
  assign out_member_count    = out_count_r;
  assign out_map_empty       = out_empty_r;
  assign out_index_error     = out_err_r;

`ifndef SYNTHESIS
  a_accept_starts_walk: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == ST_WALK) && (wcnt_r == '0) && !refill_r)
    else $error("transaction did not start a word walk");

  a_cfg_refills: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> refill_r && (state_r == ST_WALK) && (wcnt_r == '0))
    else $error("set size write did not start a refill");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_empty_r |-> (out_count_r == '0) && (out_ext_r == '0))
    else $error("empty map reported with members or an extracted index");

  a_err_not_member: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_err_r |-> !out_member_r)
    else $error("out-of-range index reported as a member");
`endif

endmodule

@@ dv/tb_index_bitmap_extract_count_top.sv @@
module tb_index_bitmap_extract_count_top
  import ibec_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_WORDS = 4;
  localparam int INDEX_LIMIT = NUM_WORDS * WORD_BITS;

  typedef struct packed {
    logic               is_member;
    logic [INDEX_W-1:0] extracted_index;
    logic [SIZE_W-1:0]  member_count;
    logic               map_empty;
    logic               index_error;
  } bitmap_result_t;

  typedef struct packed {
    cmd_t               command;
    logic [INDEX_W-1:0] index;
  } bitmap_cmd_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_we = 1'b0;
  logic [SIZE_W-1:0]  cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [CMD_W-1:0]   in_command = CMD_QUERY;
  logic [INDEX_W-1:0] in_index = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               out_is_member;
  logic [INDEX_W-1:0] out_extracted_index;
  logic [SIZE_W-1:0]  out_member_count;
  logic               out_map_empty;
  logic               out_index_error;

  index_bitmap_extract_count_top dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_data            (cfg_data),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_command          (in_command),
    .in_index            (in_index),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_is_member       (out_is_member),
    .out_extracted_index (out_extracted_index),
    .out_member_count    (out_member_count),
    .out_map_empty       (out_map_empty),
    .out_index_error     (out_index_error)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Shadow copy of the membership bitmap and the set size register.
  word_t          shadow_words [NUM_WORDS];
  int unsigned    shadow_size;

  bitmap_cmd_t    pending_items [$];
  bitmap_result_t expected_results [$];

  int unsigned    accepted_items = 0;
  int unsigned    results_checked = 0;
  int unsigned    mismatch_count = 0;
  int unsigned    sizes_programmed = 0;

  int unsigned    burst_left = 0;
  int unsigned    gap_left = 0;
  bitmap_cmd_t    next_item;
  bitmap_result_t accepted_result;

  int unsigned    stall_mode = 0;
  int unsigned    mode_left = 0;
  int unsigned    cycle_ctr = 0;
  bitmap_result_t seen_result;
  bitmap_result_t wanted_result;
  logic           ready_next;

  function automatic int unsigned live_size();
    return (shadow_size > INDEX_LIMIT) ? INDEX_LIMIT : shadow_size;
  endfunction

  function automatic word_t bits_below(int unsigned w);
    int unsigned n;
    int unsigned base;
    n = live_size();
    base = w * WORD_BITS;
    if (n >= base + WORD_BITS) return '1;
    if (n <= base) return '0;
    return (word_t'(1) << (n - base)) - word_t'(1);
  endfunction

  function automatic int unsigned top_set_bit(word_t v);
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (v[i]) return i;
    end
    return 0;
  endfunction

  task automatic refill_shadow();
    for (int i = 0; i < NUM_WORDS; i++) begin
      shadow_words[i] = bits_below(i);
    end
  endtask

  // Applies one command to the shadow bitmap and returns what the block reports.
  task automatic apply_bitmap_cmd(input cmd_t cmd, input logic [INDEX_W-1:0] idx,
                                  output bitmap_result_t r);
    int unsigned w;
    int unsigned b;
    logic        out_of_range;
    w = idx / WORD_BITS;
    b = idx % WORD_BITS;
    out_of_range = (idx >= live_size());
    case (cmd)
      CMD_FILL: begin
        refill_shadow();
      end
      CMD_TOGGLE: begin
        if (!out_of_range) shadow_words[w][b] = ~shadow_words[w][b];
      end
      CMD_COMPLEMENT: begin
        for (int i = 0; i < NUM_WORDS; i++) begin
          shadow_words[i] = ~shadow_words[i] & bits_below(i);
        end
      end
      default: ;
    endcase
    r.is_member = !out_of_range && shadow_words[w][b];
    r.index_error = out_of_range;
    r.member_count = '0;
    r.map_empty = 1'b1;
    r.extracted_index = '0;
    for (int i = 0; i < NUM_WORDS; i++) begin
      r.member_count = r.member_count + SIZE_W'($countones(shadow_words[i]));
      if (r.map_empty && shadow_words[i] != '0) begin
        r.map_empty = 1'b0;
        r.extracted_index = INDEX_W'(i * WORD_BITS + top_set_bit(shadow_words[i]));
      end
    end
  endtask

  function automatic int unsigned pick_gap();
    case ($urandom_range(0, 3))
      0: return 0;
      1: return $urandom_range(1, 3);
      2: return $urandom_range(1, 12);
      default: return 0;
    endcase
  endfunction

  // Sender: bursts of random length separated by random gaps.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      burst_left <= 0;
      gap_left <= 0;
    end else begin
      if (in_valid && in_ready) begin
        apply_bitmap_cmd(in_command, in_index, accepted_result);
        expected_results = {expected_results, accepted_result};
        accepted_items++;
      end
      if (!in_valid || in_ready) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (pending_items.size() != 0) begin
          next_item = pending_items.pop_front();
          in_command <= next_item.command;
          in_index <= next_item.index;
          in_valid <= 1'b1;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 40);
            gap_left <= pick_gap();
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each result and stalls in modes that change over time.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        seen_result.is_member = out_is_member;
        seen_result.extracted_index = out_extracted_index;
        seen_result.member_count = out_member_count;
        seen_result.map_empty = out_map_empty;
        seen_result.index_error = out_index_error;
        if (expected_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%0t: result with nothing outstanding: member=%0b idx=%0d count=%0d empty=%0b err=%0b",
                     $realtime, out_is_member, out_extracted_index, out_member_count,
                     out_map_empty, out_index_error);
        end else begin
          wanted_result = expected_results.pop_front();
          results_checked++;
          if (seen_result.is_member !== wanted_result.is_member ||
              seen_result.extracted_index !== wanted_result.extracted_index ||
              seen_result.member_count !== wanted_result.member_count ||
              seen_result.map_empty !== wanted_result.map_empty ||
              seen_result.index_error !== wanted_result.index_error) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("%0t: result %0d expected member=%0b idx=%0d count=%0d empty=%0b err=%0b, got member=%0b idx=%0d count=%0d empty=%0b err=%0b",
                       $realtime, results_checked,
                       wanted_result.is_member, wanted_result.extracted_index,
                       wanted_result.member_count, wanted_result.map_empty,
                       wanted_result.index_error,
                       seen_result.is_member, seen_result.extracted_index,
                       seen_result.member_count, seen_result.map_empty,
                       seen_result.index_error);
          end
        end
      end
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left = $urandom_range(10, 80);
      end else begin
        mode_left--;
      end
      cycle_ctr++;
      case (stall_mode)
        0: ready_next = 1'b1;
        1: ready_next = ($urandom_range(0, 3) != 0);
        2: ready_next = ($urandom_range(0, 3) == 0);
        default: ready_next = (cycle_ctr % 8) < 5;
      endcase
      out_ready <= ready_next;
    end
  end

  task automatic queue_cmd(input cmd_t cmd, input int unsigned idx);
    bitmap_cmd_t item;
    item.command = cmd;
    item.index = INDEX_W'(idx);
    pending_items = {pending_items, item};
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (pending_items.size() != 0 || in_valid || expected_results.size() != 0);
    repeat (12) @(posedge clk);
  endtask

  // The write also refills the map, so the shadow copy is refilled with it.
  task automatic program_size(input int unsigned value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= SIZE_W'(value);
    @(posedge clk);
    cfg_we <= 1'b0;
    shadow_size = value;
    refill_shadow();
    sizes_programmed++;
  endtask

  function automatic int unsigned pick_index();
    int unsigned n;
    int unsigned v;
    n = live_size();
    case ($urandom_range(0, 9))
      0: v = $urandom_range(0, 255);
      1: begin
        case ($urandom_range(0, 5))
          0: v = 0;
          1: v = (n == 0) ? 0 : n - 1;
          2: v = n;
          3: v = 63 + 64 * $urandom_range(0, 3);
          4: v = 64 * $urandom_range(0, 3);
          default: v = 255;
        endcase
      end
      default: v = (n == 0) ? $urandom_range(0, 255) : $urandom_range(0, n - 1);
    endcase
    return (v > 255) ? 255 : v;
  endfunction

  task automatic queue_random_cmds(input int unsigned count);
    int unsigned r;
    cmd_t        cmd;
    for (int unsigned k = 0; k < count; k++) begin
      r = $urandom_range(0, 19);
      if (r < 2) cmd = CMD_FILL;
      else if (r < 4) cmd = CMD_COMPLEMENT;
      else if (r < 12) cmd = CMD_TOGGLE;
      else cmd = CMD_QUERY;
      queue_cmd(cmd, pick_index());
    end
  endtask

  int unsigned sweep_sizes [12] = '{64, 65, 1, 200, 511, 0, 128, 255, 130, 256, 0, 0};

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    shadow_size = INDEX_LIMIT;
    refill_shadow();

    // Reset state: full map, then removal, empty map and higher words.
    queue_cmd(CMD_QUERY, 0);
    queue_cmd(CMD_QUERY, 255);
    queue_cmd(CMD_TOGGLE, 63);
    queue_cmd(CMD_QUERY, 63);
    queue_cmd(CMD_TOGGLE, 63);
    queue_cmd(CMD_COMPLEMENT, 0);
    queue_cmd(CMD_QUERY, 0);
    queue_cmd(CMD_TOGGLE, 255);
    queue_cmd(CMD_TOGGLE, 128);
    queue_cmd(CMD_TOGGLE, 0);
    queue_cmd(CMD_FILL, 17);
    queue_cmd(CMD_COMPLEMENT, 200);
    queue_cmd(CMD_TOGGLE, 200);
    queue_cmd(CMD_TOGGLE, 64);
    wait_drained();

    // A single index in use: everything else is out of range.
    program_size(1);
    queue_cmd(CMD_QUERY, 0);
    queue_cmd(CMD_QUERY, 1);
    queue_cmd(CMD_TOGGLE, 255);
    queue_cmd(CMD_TOGGLE, 0);
    queue_cmd(CMD_COMPLEMENT, 0);
    queue_cmd(CMD_FILL, 0);
    wait_drained();

    // A zero size keeps the map empty whatever is done to it.
    program_size(0);
    queue_cmd(CMD_FILL, 0);
    queue_cmd(CMD_QUERY, 0);
    queue_cmd(CMD_COMPLEMENT, 255);
    queue_cmd(CMD_TOGGLE, 0);
    wait_drained();

    // Oversized values saturate to the full map.
    program_size(511);
    queue_cmd(CMD_QUERY, 255);
    queue_cmd(CMD_TOGGLE, 255);
    queue_cmd(CMD_COMPLEMENT, 0);
    wait_drained();

    for (int p = 0; p < 12; p++) begin
      program_size((p >= 10) ? $urandom_range(0, 511) : sweep_sizes[p]);
      queue_random_cmds(60);
      wait_drained();
    end

    repeat (20) @(posedge clk);
    $display("Covered %0d commands over %0d set size writes; %0d results checked, %0d bad.",
             accepted_items, sizes_programmed, results_checked, mismatch_count);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Run did not finish in time; %0d results still outstanding.",
             expected_results.size());
    $display("end of test: mismatches");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/ibec_pkg.sv
rtl/core/index_bitmap_extract_count_top.sv
dv/tb_index_bitmap_extract_count_top.sv
